// File: design/bscu_pkg.sv
`default_nettype none
package bscu_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DIV_STAGES = 32;
  // stage numbering: 1..11 front end, 12..43 divider, 44..46 pressure tail
  localparam int unsigned DIV_FIRST  = 12;
  localparam int unsigned PIPE_DEPTH = DIV_FIRST + DIV_STAGES + 2;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned DATA_W     = 64;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB  = 3'd0,
    REG_PRESS_LOW   = 3'd1,
    REG_PRESS_HIGH  = 3'd2,
    REG_PRESS_LAST  = 3'd3,
    REG_HUM_CALIB   = 3'd4,
    REG_HAS_HUM     = 3'd5,
    REG_SPARE6      = 3'd6,
    REG_SPARE7      = 3'd7
  } reg_idx_t;

  localparam logic [31:0] K_64000   = 32'd64000;
  localparam logic [31:0] K_2_20    = 32'd1048576;
  localparam logic [31:0] K_3125    = 32'd3125;
  localparam logic [31:0] K_SIGN    = 32'h8000_0000;
  localparam logic [31:0] K_76800   = 32'd76800;
  localparam logic [31:0] K_CLAMP   = 32'd409600000;
  localparam logic [31:0] K_2097152 = 32'd2097152;
  localparam logic [31:0] K_16384   = 32'd16384;
  localparam logic [31:0] K_32768   = 32'd32768;
  localparam logic [31:0] K_8192    = 32'd8192;
  localparam logic [31:0] K_128     = 32'd128;

  // low word of a 32 by 32 product
  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return 32'(s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: design/barometric_sensor_compensation_unit.sv
`default_nettype none
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_ready   | in_raw_temp, in_raw_press, in_raw_hum
// out      | output    | out_valid / out_ready | out_temp_centi, out_press_pa,
//          |           |                       | out_hum_frac, out_press_valid
// cfg      | input     | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// one item enters per cycle while the output is not stalled; the depth is set by the 32 stage
// restoring divider for pressure plus the multiplier stages around it
// synchronous active low reset clears the valid bits and the calibration
// a stall at the output freezes every stage at once, so nothing is lost or repeated
module barometric_sensor_compensation_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [19:0]                  in_raw_temp,
  input  wire logic [19:0]                  in_raw_press,
  input  wire logic [15:0]                  in_raw_hum,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [31:0]                       out_temp_centi,
  output logic [31:0]                       out_press_pa,
  output logic [16:0]                       out_hum_frac,
  output logic                              out_press_valid,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bscu_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bscu_pkg::DATA_W-1:0]  pwdata,
  output logic [bscu_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned N  = bscu_pkg::PIPE_DEPTH;
  localparam int unsigned DS = bscu_pkg::DIV_STAGES;

  // calibration registers
  logic [47:0] tcal_r;
  logic [63:0] pcl_r, pch_r, hcal_r;
  logic [15:0] p9_r;
  logic        hash_r;

  bscu_pkg::reg_idx_t widx;
  assign widx   = bscu_pkg::reg_idx_t'(paddr[bscu_pkg::ADDR_W-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      pcl_r  <= '0;
      pch_r  <= '0;
      p9_r   <= '0;
      hcal_r <= '0;
      hash_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        bscu_pkg::REG_TEMP_CALIB: tcal_r <= pwdata[47:0];
        bscu_pkg::REG_PRESS_LOW:  pcl_r  <= pwdata;
        bscu_pkg::REG_PRESS_HIGH: pch_r  <= pwdata;
        bscu_pkg::REG_PRESS_LAST: p9_r   <= pwdata[15:0];
        bscu_pkg::REG_HUM_CALIB:  hcal_r <= pwdata;
        bscu_pkg::REG_HAS_HUM:    hash_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      bscu_pkg::REG_TEMP_CALIB: prdata = {16'd0, tcal_r};
      bscu_pkg::REG_PRESS_LOW:  prdata = pcl_r;
      bscu_pkg::REG_PRESS_HIGH: prdata = pch_r;
      bscu_pkg::REG_PRESS_LAST: prdata = {48'd0, p9_r};
      bscu_pkg::REG_HUM_CALIB:  prdata = hcal_r;
      bscu_pkg::REG_HAS_HUM:    prdata = {63'd0, hash_r};
      default:                  prdata = '0;
    endcase
  end

  // unpacked coefficients, all as 32-bit words
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, tcal_r[15:0]};
  assign t2 = bscu_pkg::sx16(tcal_r[31:16]);
  assign t3 = bscu_pkg::sx16(tcal_r[47:32]);
  assign p1 = {16'd0, pcl_r[15:0]};
  assign p2 = bscu_pkg::sx16(pcl_r[31:16]);
  assign p3 = bscu_pkg::sx16(pcl_r[47:32]);
  assign p4 = bscu_pkg::sx16(pcl_r[63:48]);
  assign p5 = bscu_pkg::sx16(pch_r[15:0]);
  assign p6 = bscu_pkg::sx16(pch_r[31:16]);
  assign p7 = bscu_pkg::sx16(pch_r[47:32]);
  assign p8 = bscu_pkg::sx16(pch_r[63:48]);
  assign p9 = bscu_pkg::sx16(p9_r);
  assign h1 = {24'd0, hcal_r[7:0]};
  assign h2 = bscu_pkg::sx16(hcal_r[23:8]);
  assign h3 = {24'd0, hcal_r[31:24]};
  assign h4 = bscu_pkg::sx12(hcal_r[43:32]);
  assign h5 = bscu_pkg::sx12(hcal_r[55:44]);
  assign h6 = bscu_pkg::sx8(hcal_r[63:56]);

  // global advance: every stage moves when the output slot is free or taken
  logic en;
  logic vld_r [1:N];
  assign en        = !vld_r[N] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int k = 2; k <= N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // raw reading delay lines
  logic [19:0] ap_r [1:9];
  logic [15:0] ah_r [1:6];

  // temperature and shared front end
  logic [31:0] ta1_r, td1_r, m1_2_r, m2_2_r, a3_r, m3_3_r, tf4_r;
  logic [31:0] temp_r [5:N];
  // pressure front end
  logic [31:0] pa5_r, pd5_r, dd6_r, ma5_6_r, ma2_6_r;
  logic [31:0] b1_7_r, m3a_7_r, ma5_7_r, ma2_7_r;
  logic [31:0] b8_r, a8_r, av9_r, bsh9_r, adiv10_r, pn10_r, pm11_r, adiv11_r;
  // humidity
  logic [31:0] hv5_r, mh5_6_r, my6_r, mz6_r, x7_r, y7_r, z7_r;
  logic [31:0] myz8_r, x8_r, w9_r, x9_r, mw10_r, x10_r, w2_11_r, x11_r;
  logic [31:0] vv12_r, vv13_r, s13_r, vv14_r, ss14_r, vv15_r, sh15_r;
  logic [16:0] hum_r [16:N];

  logic [31:0] ta_nxt, hx_nxt, hr_nxt;
  logic [16:0] hum_nxt;

  assign ta_nxt = ({12'd0, in_raw_temp} >> 3) - (t1 << 1);
  assign hx_nxt = bscu_pkg::asr(({16'd0, ah_r[6]} << 14) - (h4 << 20) - mh5_6_r
                                + bscu_pkg::K_16384, 15);

  always_comb begin
    hr_nxt = vv15_r - bscu_pkg::asr(sh15_r, 4);
    if (hr_nxt[31])                   hr_nxt = '0;
    if (hr_nxt > bscu_pkg::K_CLAMP)   hr_nxt = bscu_pkg::K_CLAMP;
    hum_nxt = hash_r ? hr_nxt[28:12] : 17'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r[1] <= in_raw_press;
      for (int k = 2; k <= 9; k++) ap_r[k] <= ap_r[k-1];
      ah_r[1] <= in_raw_hum;
      for (int k = 2; k <= 6; k++) ah_r[k] <= ah_r[k-1];

      // s1: operand differences
      ta1_r  <= ta_nxt;
      td1_r  <= ({12'd0, in_raw_temp} >> 4) - t1;
      // s2
      m1_2_r <= bscu_pkg::mul(ta1_r, t2);
      m2_2_r <= bscu_pkg::mul(td1_r, td1_r);
      // s3
      a3_r   <= bscu_pkg::asr(m1_2_r, 11);
      m3_3_r <= bscu_pkg::mul(bscu_pkg::asr(m2_2_r, 12), t3);
      // s4: fine temperature
      tf4_r  <= a3_r + bscu_pkg::asr(m3_3_r, 14);
      // s5
      temp_r[5] <= bscu_pkg::asr(bscu_pkg::mul(tf4_r, 32'd5) + bscu_pkg::K_128, 8);
      for (int k = 6; k <= N; k++) temp_r[k] <= temp_r[k-1];
      pa5_r  <= bscu_pkg::asr(tf4_r, 1) - bscu_pkg::K_64000;
      pd5_r  <= bscu_pkg::asr(bscu_pkg::asr(tf4_r, 1) - bscu_pkg::K_64000, 2);
      hv5_r  <= tf4_r - bscu_pkg::K_76800;
      // s6
      dd6_r   <= bscu_pkg::mul(pd5_r, pd5_r);
      ma5_6_r <= bscu_pkg::mul(pa5_r, p5);
      ma2_6_r <= bscu_pkg::mul(p2, pa5_r);
      mh5_6_r <= bscu_pkg::mul(h5, hv5_r);
      my6_r   <= bscu_pkg::mul(hv5_r, h6);
      mz6_r   <= bscu_pkg::mul(hv5_r, h3);
      // s7
      b1_7_r  <= bscu_pkg::mul(bscu_pkg::asr(dd6_r, 11), p6);
      m3a_7_r <= bscu_pkg::mul(p3, bscu_pkg::asr(dd6_r, 13));
      ma5_7_r <= ma5_6_r;
      ma2_7_r <= ma2_6_r;
      x7_r    <= hx_nxt;
      y7_r    <= bscu_pkg::asr(my6_r, 10);
      z7_r    <= bscu_pkg::asr(mz6_r, 11) + bscu_pkg::K_32768;
      // s8
      b8_r    <= bscu_pkg::asr(b1_7_r + (ma5_7_r << 1), 2) + (p4 << 16);
      a8_r    <= bscu_pkg::asr(bscu_pkg::asr(m3a_7_r, 3) + bscu_pkg::asr(ma2_7_r, 1), 18);
      myz8_r  <= bscu_pkg::mul(y7_r, z7_r);
      x8_r    <= x7_r;
      // s9
      av9_r   <= bscu_pkg::mul(bscu_pkg::K_32768 + a8_r, p1);
      bsh9_r  <= bscu_pkg::asr(b8_r, 12);
      w9_r    <= bscu_pkg::asr(myz8_r, 10) + bscu_pkg::K_2097152;
      x9_r    <= x8_r;
      // s10
      adiv10_r <= bscu_pkg::asr(av9_r, 15);
      pn10_r   <= (bscu_pkg::K_2_20 - {12'd0, ap_r[9]}) - bsh9_r;
      mw10_r   <= bscu_pkg::mul(w9_r, h2);
      x10_r    <= x9_r;
      // s11
      pm11_r   <= bscu_pkg::mul(pn10_r, bscu_pkg::K_3125);
      adiv11_r <= adiv10_r;
      w2_11_r  <= bscu_pkg::asr(mw10_r + bscu_pkg::K_8192, 14);
      x11_r    <= x10_r;
      // s12..s16: humidity tail
      vv12_r <= bscu_pkg::mul(x11_r, w2_11_r);
      vv13_r <= vv12_r;
      s13_r  <= bscu_pkg::asr(vv12_r, 15);
      vv14_r <= vv13_r;
      ss14_r <= bscu_pkg::mul(s13_r, s13_r);
      vv15_r <= vv14_r;
      sh15_r <= bscu_pkg::mul(bscu_pkg::asr(ss14_r, 7), h1);
      hum_r[16] <= hum_nxt;
      for (int k = 17; k <= N; k++) hum_r[k] <= hum_r[k-1];
    end
  end

  // restoring divider, one quotient bit per stage
  // a numerator below 2^31 is doubled before dividing, else the quotient is doubled afterwards
  logic [31:0] dq_r   [0:DS-1];
  logic [31:0] rem_r  [0:DS-1];
  logic [31:0] dvs_r  [0:DS-1];
  logic        dbl_r  [0:DS-1];
  logic        zero_r [0:DS-1];

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [31:0] rem_in, dq_in, dvs_in;
    logic        dbl_in, zero_in, ge;
    logic [32:0] shifted, diff;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = pm11_r[31] ? pm11_r : (pm11_r << 1);
      assign dvs_in  = adiv11_r;
      assign dbl_in  = pm11_r[31];
      assign zero_in = (adiv11_r == '0);
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign dq_in   = dq_r[i-1];
      assign dvs_in  = dvs_r[i-1];
      assign dbl_in  = dbl_r[i-1];
      assign zero_in = zero_r[i-1];
    end
    assign shifted = {rem_in, dq_in[31]};
    assign diff    = shifted - {1'b0, dvs_in};
    assign ge      = !diff[32];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[31:0] : shifted[31:0];
        dq_r[i]   <= {dq_in[30:0], ge};
        dvs_r[i]  <= dvs_in;
        dbl_r[i]  <= dbl_in;
        zero_r[i] <= zero_in;
      end
    end
  end

  // pressure tail
  logic [31:0] pq_nxt;
  logic [31:0] p44_r, qq44_r, c2m44_r, p45_r, c1m45_r, c2_45_r, press_r;
  logic        ok44_r, ok45_r, ok46_r;

  assign pq_nxt = dbl_r[DS-1] ? (dq_r[DS-1] << 1) : dq_r[DS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      p44_r   <= pq_nxt;
      qq44_r  <= bscu_pkg::mul(pq_nxt >> 3, pq_nxt >> 3);
      c2m44_r <= bscu_pkg::mul(pq_nxt >> 2, p8);
      ok44_r  <= !zero_r[DS-1];
      p45_r   <= p44_r;
      c1m45_r <= bscu_pkg::mul(p9, qq44_r >> 13);
      c2_45_r <= bscu_pkg::asr(c2m44_r, 13);
      ok45_r  <= ok44_r;
      press_r <= ok45_r ? p45_r + bscu_pkg::asr(bscu_pkg::asr(c1m45_r, 12) + c2_45_r + p7, 4)
                        : 32'd0;
      ok46_r  <= ok45_r;
    end
  end

  assign out_temp_centi  = temp_r[N];
  assign out_hum_frac    = hum_r[N];
  assign out_press_pa    = press_r;
  assign out_press_valid = ok46_r;

endmodule
`default_nettype wire

// File: design/bscu_checker.sv
`default_nettype none
module bscu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_press_pa,
  input wire logic [16:0] out_hum_frac,
  input wire logic        out_press_valid,
  input wire logic        pready
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // invalid divisor reports zero pressure
  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_press_valid |-> out_press_pa == 32'd0)
    else $error("pressure not zero on invalid divisor");

  // humidity stays within the clamp
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hum_frac <= 17'd100000)
    else $error("humidity beyond range");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind barometric_sensor_compensation_unit bscu_checker u_bscu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_press_pa    (out_press_pa),
  .out_hum_frac    (out_hum_frac),
  .out_press_valid (out_press_valid),
  .pready          (pready)
);
`default_nettype wire

// File: sim/barometric_sensor_compensation_unit_test.sv
`default_nettype none
module barometric_sensor_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth, equal to the block's stage count
  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_pa;
    logic [16:0] hum_frac;
    logic        press_valid;
  } reading_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [19:0] in_raw_temp, in_raw_press;
  logic [15:0] in_raw_hum;
  logic out_valid, out_ready;
  logic [31:0] out_temp_centi, out_press_pa;
  logic [16:0] out_hum_frac;
  logic out_press_valid;
  logic psel, penable, pwrite;
  logic [bscu_pkg::ADDR_W-1:0] paddr;
  logic [bscu_pkg::DATA_W-1:0] pwdata, prdata;
  logic pready;

  barometric_sensor_compensation_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_temp(in_raw_temp), .in_raw_press(in_raw_press), .in_raw_hum(in_raw_hum),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temp_centi(out_temp_centi), .out_press_pa(out_press_pa),
    .out_hum_frac(out_hum_frac), .out_press_valid(out_press_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo, cal_press_hi, cal_hum;
  logic [15:0] cal_p9;
  logic        cal_has_hum;

  reading_t expected_readings[$];
  int  fail_count;
  int  idle_cycles;
  bit  sender_calm, receiver_calm;
  int  hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // 32-bit word helpers, written independently of the package
  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] lo_prod(logic [31:0] a, logic [31:0] b);
    logic [63:0] full;
    full = {32'd0, a} * {32'd0, b};
    return full[31:0];
  endfunction

  // compensation arithmetic for one raw triple
  function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, d, fine, p, q, c1, c2, v, x, y, z, w, s;
    reading_t r;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {16'd0, cal_press_lo[15:0]};
    p2 = {{16{cal_press_lo[31]}}, cal_press_lo[31:16]};
    p3 = {{16{cal_press_lo[47]}}, cal_press_lo[47:32]};
    p4 = {{16{cal_press_lo[63]}}, cal_press_lo[63:48]};
    p5 = {{16{cal_press_hi[15]}}, cal_press_hi[15:0]};
    p6 = {{16{cal_press_hi[31]}}, cal_press_hi[31:16]};
    p7 = {{16{cal_press_hi[47]}}, cal_press_hi[47:32]};
    p8 = {{16{cal_press_hi[63]}}, cal_press_hi[63:48]};
    p9 = {{16{cal_p9[15]}}, cal_p9};
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
    r = '0;
    // temperature and fine value
    a = sra(lo_prod(({12'd0, rt} >> 3) - (t1 << 1), t2), 11);
    d = ({12'd0, rt} >> 4) - t1;
    b = sra(lo_prod(sra(lo_prod(d, d), 12), t3), 14);
    fine = a + b;
    r.temp_centi = sra(lo_prod(fine, 32'd5) + 32'd128, 8);
    // pressure
    a = sra(fine, 1) - 32'd64000;
    d = sra(a, 2);
    b = lo_prod(sra(lo_prod(d, d), 11), p6);
    b = b + (lo_prod(a, p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(lo_prod(p3, sra(lo_prod(d, d), 13)), 3) + sra(lo_prod(p2, a), 1), 18);
    a = sra(lo_prod(32'd32768 + a, p1), 15);
    if (a != 0) begin
      p = lo_prod((32'd1048576 - {12'd0, rp}) - sra(b, 12), 32'd3125);
      if (!p[31]) p = (p << 1) / a;
      else p = (p / a) * 2;
      q = p >> 3;
      c1 = sra(lo_prod(p9, lo_prod(q, q) >> 13), 12);
      c2 = sra(lo_prod(p >> 2, p8), 13);
      r.press_pa = p + sra(c1 + c2 + p7, 4);
      r.press_valid = 1'b1;
    end
    // humidity, clamped before the final shift
    if (cal_has_hum) begin
      v = fine - 32'd76800;
      x = sra((({16'd0, rh} << 14) - (h4 << 20) - lo_prod(h5, v)) + 32'd16384, 15);
      y = sra(lo_prod(v, h6), 10);
      z = sra(lo_prod(v, h3), 11) + 32'd32768;
      w = sra(lo_prod(y, z), 10) + 32'd2097152;
      w = sra(lo_prod(w, h2) + 32'd8192, 14);
      v = lo_prod(x, w);
      s = sra(v, 15);
      v = v - sra(lo_prod(sra(lo_prod(s, s), 7), h1), 4);
      if (v[31]) v = 0;
      if (v > 32'd409600000) v = 32'd409600000;
      r.hum_frac = 17'(v >> 12);
    end
    return r;
  endfunction

  task automatic write_calib(bscu_pkg::reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bscu_pkg::REG_TEMP_CALIB: cal_temp     = value[47:0];
      bscu_pkg::REG_PRESS_LOW:  cal_press_lo = value;
      bscu_pkg::REG_PRESS_HIGH: cal_press_hi = value;
      bscu_pkg::REG_PRESS_LAST: cal_p9       = value[15:0];
      bscu_pkg::REG_HUM_CALIB:  cal_hum      = value;
      bscu_pkg::REG_HAS_HUM:    cal_has_hum  = value[0];
      default: ;
    endcase
  endtask

  // one item, with a random gap beforehand unless the sender is calm
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    while (!sender_calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temp <= rt; in_raw_press <= rp; in_raw_hum <= rh;
    expected_readings.push_back(compensate(rt, rp, rh));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // plausible calibration near a real part, with random jitter
  task automatic load_typical_calib;
    write_calib(bscu_pkg::REG_TEMP_CALIB, {16'd50, 16'd26435, 16'd27504});
    write_calib(bscu_pkg::REG_PRESS_LOW, {16'd2855, 16'hD0D0 ^ 16'($urandom_range(255)),
                                          16'hD50A, 16'd36477});
    write_calib(bscu_pkg::REG_PRESS_HIGH, {16'd3024, 16'hC1B8, 16'hFFF9, 16'd140});
    write_calib(bscu_pkg::REG_PRESS_LAST, 64'd4883);
    write_calib(bscu_pkg::REG_HUM_CALIB, {8'd30, 12'd50, 12'd339, 8'd0, 16'd362, 8'd75});
    write_calib(bscu_pkg::REG_HAS_HUM, 64'd1);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  task automatic load_random_calib;
    write_calib(bscu_pkg::REG_TEMP_CALIB, rand64());
    write_calib(bscu_pkg::REG_PRESS_LOW, rand64());
    write_calib(bscu_pkg::REG_PRESS_HIGH, rand64());
    write_calib(bscu_pkg::REG_PRESS_LAST, 64'($urandom_range(65535)));
    write_calib(bscu_pkg::REG_HUM_CALIB, rand64());
    write_calib(bscu_pkg::REG_HAS_HUM, 64'($urandom_range(1)));
  endtask

  // reset calibration: all zero, so p1 = 0 gives the zero divisor case
  task automatic test_zero_calib;
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading(20'h80000, 20'h7FFFF, 16'h8000);
    drain();
  endtask

  task automatic test_extremes;
    load_typical_calib();
    send_reading(20'd519888, 20'd415148, 16'd27000);
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading('0, '1, 16'hFFFF);
    send_reading('1, '0, 16'h0000);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555);
    drain();
    // no humidity channel
    write_calib(bscu_pkg::REG_HAS_HUM, 64'd0);
    send_reading(20'd519888, 20'd415148, 16'd27000);
    send_reading('1, '1, '1);
    drain();
    // all-ones and most negative coefficients
    write_calib(bscu_pkg::REG_TEMP_CALIB, '1);
    write_calib(bscu_pkg::REG_PRESS_LOW, '1);
    write_calib(bscu_pkg::REG_PRESS_HIGH, '1);
    write_calib(bscu_pkg::REG_PRESS_LAST, 64'hFFFF);
    write_calib(bscu_pkg::REG_HUM_CALIB, '1);
    write_calib(bscu_pkg::REG_HAS_HUM, 64'd1);
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    drain();
    write_calib(bscu_pkg::REG_TEMP_CALIB, {16'h8000, 16'h8000, 16'hFFFF});
    write_calib(bscu_pkg::REG_PRESS_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    write_calib(bscu_pkg::REG_PRESS_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_calib(bscu_pkg::REG_PRESS_LAST, 64'h8000);
    write_calib(bscu_pkg::REG_HUM_CALIB,
                {8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
    send_reading(20'h12345, '1, 16'hFFFF);
    send_reading('1, '0, 16'h0000);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        drain();
        if ($urandom_range(2) == 0) load_random_calib();
        else load_typical_calib();
      end
      if ($urandom_range(3) != 0)
        send_reading(20'd400000 + 20'($urandom_range(200000)),
                     20'd250000 + 20'($urandom_range(300000)), 16'($urandom));
      else
        send_reading(20'($urandom), 20'($urandom), 16'($urandom));
    end
    drain();
  endtask

  // a long run with no gaps on either side
  task automatic test_streaming;
    load_typical_calib();
    sender_calm = 1'b1; receiver_calm = 1'b1;
    for (int i = 0; i < 80; i++)
      send_reading(20'($urandom), 20'($urandom), 16'($urandom));
    sender_calm = 1'b0; receiver_calm = 1'b0;
    drain();
  endtask

  // receiver holds off while the sender keeps pushing, so the pipe fills
  task automatic test_backpressure;
    hold_off = 150;
    sender_calm = 1'b1;
    for (int i = 0; i < 70; i++)
      send_reading(20'($urandom), 20'($urandom), 16'($urandom));
    sender_calm = 1'b0;
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_temp_centi !== want.temp_centi) begin
          $error("temp_centi: expected %0d, got %0d", $signed(want.temp_centi),
                 $signed(out_temp_centi));
          fail_count++;
        end
        if (out_press_pa !== want.press_pa) begin
          $error("press_pa: expected %0d, got %0d", want.press_pa, out_press_pa);
          fail_count++;
        end
        if (out_hum_frac !== want.hum_frac) begin
          $error("hum_frac: expected %0d, got %0d", want.hum_frac, out_hum_frac);
          fail_count++;
        end
        if (out_press_valid !== want.press_valid) begin
          $error("press_valid: expected %0d, got %0d", want.press_valid,
                 out_press_valid);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls, plus the long hold-off counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (receiver_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 27);
    end
  end

  // watchdog on stretches with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_raw_temp = '0; in_raw_press = '0; in_raw_hum = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0; cal_p9 = '0;
    cal_hum = '0; cal_has_hum = 1'b0;
    fail_count = 0; idle_cycles = 0; hold_off = 0;
    sender_calm = 1'b0; receiver_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_calib();
    test_extremes();
    test_streaming();
    test_backpressure();
    test_random(400);
    drain();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
